// ----- sv/qdcm_pkg.sv -----
// shared types and constants for the quaternion to rotation matrix unit
package qdcm_pkg;

  // input component and matrix entry types
  typedef logic signed [15:0] qcomp_t;
  typedef logic signed [16:0] entry_t;

  // datapath widths
  localparam int unsigned ProdW = 32;           // one 16x16 signed product
  localparam int unsigned NumW  = 34;           // signed quadratic form
  localparam int unsigned DenW  = 33;           // sum of squares, up to 2**32
  localparam int unsigned RemW  = 34;           // partial remainder incl. shift
  localparam int unsigned QuoW  = 17;           // floor(mag * 2**16 / den)

  // matrix layout
  localparam int unsigned NumEnt  = 9;
  localparam int unsigned NumProd = 10;

  // product slots
  localparam int unsigned P_AA = 0;
  localparam int unsigned P_BB = 1;
  localparam int unsigned P_CC = 2;
  localparam int unsigned P_DD = 3;
  localparam int unsigned P_BC = 4;
  localparam int unsigned P_AD = 5;
  localparam int unsigned P_BD = 6;
  localparam int unsigned P_AC = 7;
  localparam int unsigned P_CD = 8;
  localparam int unsigned P_AB = 9;

  // pipeline shape: input, products, forms, magnitudes, divide steps, output
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned StgIn    = 0;
  localparam int unsigned StgProd  = 1;
  localparam int unsigned StgNum   = 2;
  localparam int unsigned StgDiv0  = 3;
  localparam int unsigned StgOut   = StgDiv0 + DivSteps + 1;
  localparam int unsigned NumStg   = StgOut + 1;

  // unity in Q1.15
  localparam entry_t OneQ15 = 17'sd32768;

  // state of one divide stage, all nine lanes
  typedef struct packed {
    logic [NumEnt-1:0]                neg;
    logic [NumEnt-1:0][RemW-1:0]      rem;
    logic [NumEnt-1:0][QuoW-1:0]      quo;
    logic [DenW-1:0]                  den;
    logic                             zero;
  } div_stage_t;

endpackage

// ----- sv/quaternion_to_rotation_matrix_unit.sv -----
// quaternion to direction cosine matrix, Q1.15 entries, fully pipelined
//
// channel  dir  ports                                            item
// in       in   in_valid/in_ready, in_q_scalar..in_q_z           one quaternion
// out      out  out_valid/out_ready, out_m00..m22, out_zero_error one matrix
//
// one item per cycle while out_ready is high
// the depth is set by the 17-step restoring divider, one quotient bit a stage,
// nine lanes side by side against the shared sum of squares
// each stage holds its item while the stage after it is full and stalled,
// so bubbles are squeezed out and nothing is dropped or repeated
// rst_n clears all stage valid bits; payload registers are not reset
module quaternion_to_rotation_matrix_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qdcm_pkg::qcomp_t  in_q_scalar,
  input  qdcm_pkg::qcomp_t  in_q_x,
  input  qdcm_pkg::qcomp_t  in_q_y,
  input  qdcm_pkg::qcomp_t  in_q_z,
  output logic              out_valid,
  input  logic              out_ready,
  output qdcm_pkg::entry_t  out_m00,
  output qdcm_pkg::entry_t  out_m01,
  output qdcm_pkg::entry_t  out_m02,
  output qdcm_pkg::entry_t  out_m10,
  output qdcm_pkg::entry_t  out_m11,
  output qdcm_pkg::entry_t  out_m12,
  output qdcm_pkg::entry_t  out_m20,
  output qdcm_pkg::entry_t  out_m21,
  output qdcm_pkg::entry_t  out_m22,
  output logic              out_zero_error
);
  import qdcm_pkg::*;

  // stage valid bits and per-stage advance
  logic [NumStg-1:0] vld_r;
  logic [NumStg-1:0] adv;

  // stage payloads
  qcomp_t                         a_r, b_r, c_r, d_r;
  logic signed [ProdW-1:0]        prod_r [NumProd];
  logic signed [NumW-1:0]         num_r  [NumEnt];
  logic [DenW-1:0]                den_r;
  div_stage_t                     div_r  [DivSteps+1];
  entry_t                         ent_r  [NumEnt];
  logic                           zero_r;

  // a stage moves when it is empty or the next stage moves
  always_comb begin
    adv[NumStg-1] = !vld_r[NumStg-1] || out_ready;
    for (int i = NumStg - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ready = adv[StgIn];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[StgIn]) begin
        vld_r[StgIn] <= in_valid;
      end
      for (int i = 1; i < NumStg; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv[StgIn]) begin
      a_r <= in_q_scalar;
      b_r <= in_q_x;
      c_r <= in_q_y;
      d_r <= in_q_z;
    end
  end

  // ten 16x16 products
  always_ff @(posedge clk) begin
    if (adv[StgProd]) begin
      prod_r[P_AA] <= a_r * a_r;
      prod_r[P_BB] <= b_r * b_r;
      prod_r[P_CC] <= c_r * c_r;
      prod_r[P_DD] <= d_r * d_r;
      prod_r[P_BC] <= b_r * c_r;
      prod_r[P_AD] <= a_r * d_r;
      prod_r[P_BD] <= b_r * d_r;
      prod_r[P_AC] <= a_r * c_r;
      prod_r[P_CD] <= c_r * d_r;
      prod_r[P_AB] <= a_r * b_r;
    end
  end

  // quadratic forms and sum of squares
  logic signed [NumW-1:0] px [NumProd];

  always_comb begin
    for (int p = 0; p < NumProd; p++) begin
      px[p] = NumW'(prod_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[StgNum]) begin
      num_r[0] <= px[P_AA] + px[P_BB] - px[P_CC] - px[P_DD];
      num_r[1] <= (px[P_BC] + px[P_AD]) <<< 1;
      num_r[2] <= (px[P_BD] - px[P_AC]) <<< 1;
      num_r[3] <= (px[P_BC] - px[P_AD]) <<< 1;
      num_r[4] <= px[P_AA] - px[P_BB] + px[P_CC] - px[P_DD];
      num_r[5] <= (px[P_CD] + px[P_AB]) <<< 1;
      num_r[6] <= (px[P_BD] + px[P_AC]) <<< 1;
      num_r[7] <= (px[P_CD] - px[P_AB]) <<< 1;
      num_r[8] <= px[P_AA] - px[P_BB] - px[P_CC] + px[P_DD];
      den_r    <= DenW'(prod_r[P_AA][ProdW-2:0]) + DenW'(prod_r[P_BB][ProdW-2:0])
                + DenW'(prod_r[P_CC][ProdW-2:0]) + DenW'(prod_r[P_DD][ProdW-2:0]);
    end
  end

  // sign and magnitude of each form, divider seed
  always_ff @(posedge clk) begin
    if (adv[StgDiv0]) begin
      for (int e = 0; e < NumEnt; e++) begin
        div_r[0].neg[e] <= num_r[e][NumW-1];
        div_r[0].rem[e] <= num_r[e][NumW-1] ? RemW'(-num_r[e]) : RemW'(num_r[e]);
        div_r[0].quo[e] <= '0;
      end
      div_r[0].den  <= den_r;
      div_r[0].zero <= (den_r == '0);
    end
  end

  // restoring divide, one quotient bit per stage; the first step does not shift
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [RemW-1:0] cand [NumEnt];
    logic [NumEnt-1:0] qbit;

    always_comb begin
      for (int e = 0; e < NumEnt; e++) begin
        if (k == 0) begin
          cand[e] = div_r[k].rem[e];
        end else begin
          cand[e] = {div_r[k].rem[e][RemW-2:0], 1'b0};
        end
        qbit[e] = (cand[e] >= RemW'(div_r[k].den));
      end
    end

    always_ff @(posedge clk) begin
      if (adv[StgDiv0+k+1]) begin
        for (int e = 0; e < NumEnt; e++) begin
          div_r[k+1].rem[e] <= qbit[e] ? cand[e] - RemW'(div_r[k].den) : cand[e];
          div_r[k+1].quo[e] <= {div_r[k].quo[e][QuoW-2:0], qbit[e]};
        end
        div_r[k+1].neg  <= div_r[k].neg;
        div_r[k+1].den  <= div_r[k].den;
        div_r[k+1].zero <= div_r[k].zero;
      end
    end
  end

  // round half away from zero, restore sign, identity on zero input
  logic [QuoW:0]  rnd_sum [NumEnt];
  entry_t         rnd_mag [NumEnt];

  always_comb begin
    for (int e = 0; e < NumEnt; e++) begin
      rnd_sum[e] = {1'b0, div_r[DivSteps].quo[e]} + (QuoW+1)'(1);
      rnd_mag[e] = entry_t'(rnd_sum[e][QuoW:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[StgOut]) begin
      for (int e = 0; e < NumEnt; e++) begin
        if (div_r[DivSteps].zero) begin
          ent_r[e] <= (e % 4 == 0) ? OneQ15 : '0;
        end else if (div_r[DivSteps].neg[e]) begin
          ent_r[e] <= -rnd_mag[e];
        end else begin
          ent_r[e] <= rnd_mag[e];
        end
      end
      zero_r <= div_r[DivSteps].zero;
    end
  end

  // result ports
  assign out_valid      = vld_r[StgOut];
  assign out_m00        = ent_r[0];
  assign out_m01        = ent_r[1];
  assign out_m02        = ent_r[2];
  assign out_m10        = ent_r[3];
  assign out_m11        = ent_r[4];
  assign out_m12        = ent_r[5];
  assign out_m20        = ent_r[6];
  assign out_m21        = ent_r[7];
  assign out_m22        = ent_r[8];
  assign out_zero_error = zero_r;

  // zero flag agrees with the divisor it was derived from
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[StgDiv0] |-> (div_r[0].zero == (div_r[0].den == '0)))
    else $error("zero flag does not match sum of squares");

  // divider leaves a remainder below the divisor in the first lane
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[StgOut-1] && !div_r[DivSteps].zero)
      |-> (div_r[DivSteps].rem[0] < RemW'(div_r[DivSteps].den)))
    else $error("final remainder not below divisor");

  // the m11 quotient (lane 4) never passes unity at twice resolution
  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[StgOut-1] && !div_r[DivSteps].zero)
      |-> (div_r[DivSteps].quo[4] <= QuoW'(65536)))
    else $error("diagonal quotient exceeds unity");

  // zero input gives ones on the diagonal and zeros in m01, m12 and m20
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_error)
      |-> (out_m00 == OneQ15 && out_m11 == OneQ15 && out_m22 == OneQ15 &&
           out_m01 == '0 && out_m12 == '0 && out_m20 == '0))
    else $error("zero quaternion did not give identity");

  // a stalled result stays in the output stage
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_m01) && $stable(out_m22)))
    else $error("stalled result changed");

endmodule

// ----- tb/dcm_checker.sv -----
// checker for the quaternion to rotation matrix unit: predicts each matrix and compares
`timescale 1ns / 100ps

module dcm_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  qdcm_pkg::qcomp_t  in_q_scalar,
  input  qdcm_pkg::qcomp_t  in_q_x,
  input  qdcm_pkg::qcomp_t  in_q_y,
  input  qdcm_pkg::qcomp_t  in_q_z,
  input  logic              out_valid,
  input  logic              out_ready,
  input  qdcm_pkg::entry_t  out_m00,
  input  qdcm_pkg::entry_t  out_m01,
  input  qdcm_pkg::entry_t  out_m02,
  input  qdcm_pkg::entry_t  out_m10,
  input  qdcm_pkg::entry_t  out_m11,
  input  qdcm_pkg::entry_t  out_m12,
  input  qdcm_pkg::entry_t  out_m20,
  input  qdcm_pkg::entry_t  out_m21,
  input  qdcm_pkg::entry_t  out_m22,
  input  logic              out_zero_error,
  output int                fail_count,
  output int                pending,
  output int                matrices_checked,
  output int                zero_seen
);
  import qdcm_pkg::*;

  // one matrix item, entry index is row * 3 + column
  typedef struct packed {
    logic            zero;
    entry_t [8:0]    m;
  } dcm_t;

  dcm_t  expected_dcms[$];
  string entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  // form * 2**15 / sum of squares, rounded half away from zero
  function automatic entry_t round_q15(longint form, longint sum_sq);
    longint mag;
    longint quo;
    mag = (form < 0) ? -form : form;
    quo = (2 * mag * 32768 + sum_sq) / (2 * sum_sq);
    return entry_t'((form < 0) ? -quo : quo);
  endfunction

  // direction cosine matrix of one quaternion, normalized by its sum of squares
  function automatic dcm_t predict_dcm(qcomp_t qa, qcomp_t qb, qcomp_t qc, qcomp_t qd);
    longint a, b, c, d, aa, bb, cc, dd, sum_sq;
    longint form [9];
    dcm_t   r;
    a = qa;
    b = qb;
    c = qc;
    d = qd;
    aa = a * a;
    bb = b * b;
    cc = c * c;
    dd = d * d;
    sum_sq = aa + bb + cc + dd;
    // all-zero quaternion flags an error and gives the identity
    if (sum_sq == 0) begin
      r.zero = 1'b1;
      for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? OneQ15 : entry_t'(0);
      return r;
    end
    form[0] = aa + bb - cc - dd;
    form[1] = 2 * (b * c + a * d);
    form[2] = 2 * (b * d - a * c);
    form[3] = 2 * (b * c - a * d);
    form[4] = aa - bb + cc - dd;
    form[5] = 2 * (c * d + a * b);
    form[6] = 2 * (b * d + a * c);
    form[7] = 2 * (c * d - a * b);
    form[8] = aa - bb - cc + dd;
    r.zero = 1'b0;
    for (int i = 0; i < 9; i++) r.m[i] = round_q15(form[i], sum_sq);
    return r;
  endfunction

  // one line per mismatch, and count it
  task automatic report_mismatch(string what, longint seen, longint wanted);
    fail_count++;
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, seen, wanted);
  endtask

  // queue a prediction per accepted quaternion, compare each accepted matrix
  always @(posedge clk) begin
    dcm_t seen_dcm;
    dcm_t want_dcm;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_dcms.push_back(predict_dcm(in_q_scalar, in_q_x, in_q_y, in_q_z));
      end
      if (out_valid && out_ready) begin
        seen_dcm.zero = out_zero_error;
        seen_dcm.m = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10,
                      out_m02, out_m01, out_m00};
        if (expected_dcms.size() == 0) begin
          report_mismatch("matrix item with none outstanding", 0, 0);
        end else begin
          want_dcm = expected_dcms.pop_front();
          matrices_checked++;
          if (want_dcm.zero) zero_seen++;
          if (seen_dcm.zero !== want_dcm.zero)
            report_mismatch("zero_error", seen_dcm.zero, want_dcm.zero);
          for (int i = 0; i < 9; i++) begin
            if (seen_dcm.m[i] !== want_dcm.m[i])
              report_mismatch(entry_name[i], longint'($signed(seen_dcm.m[i])),
                              longint'($signed(want_dcm.m[i])));
          end
        end
      end
      pending = expected_dcms.size();
    end
  end

endmodule

// ----- tb/tb_quaternion_to_rotation_matrix_unit.sv -----
// testbench top for the quaternion to rotation matrix unit: stimulus, flow control, verdict
`timescale 1ns / 100ps

module tb_quaternion_to_rotation_matrix_unit;
  import qdcm_pkg::*;

  localparam qcomp_t QMin      = 16'sh8000;
  localparam qcomp_t QMax      = 16'sh7fff;
  localparam int     IdleLimit = 2000;
  localparam int     NumRandom = 640;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  qcomp_t in_q_scalar = '0;
  qcomp_t in_q_x = '0;
  qcomp_t in_q_y = '0;
  qcomp_t in_q_z = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  entry_t out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21, out_m22;
  logic   out_zero_error;

  int fail_count;
  int pending;
  int matrices_checked;
  int zero_seen;
  int quats_sent;
  int nogap_left;
  int idle_cycles;

  always #5 clk = ~clk;

  quaternion_to_rotation_matrix_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_q_scalar    (in_q_scalar),
    .in_q_x         (in_q_x),
    .in_q_y         (in_q_y),
    .in_q_z         (in_q_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_m00        (out_m00),
    .out_m01        (out_m01),
    .out_m02        (out_m02),
    .out_m10        (out_m10),
    .out_m11        (out_m11),
    .out_m12        (out_m12),
    .out_m20        (out_m20),
    .out_m21        (out_m21),
    .out_m22        (out_m22),
    .out_zero_error (out_zero_error)
  );

  dcm_checker dcm_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_q_scalar      (in_q_scalar),
    .in_q_x           (in_q_x),
    .in_q_y           (in_q_y),
    .in_q_z           (in_q_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_m00          (out_m00),
    .out_m01          (out_m01),
    .out_m02          (out_m02),
    .out_m10          (out_m10),
    .out_m11          (out_m11),
    .out_m12          (out_m12),
    .out_m20          (out_m20),
    .out_m21          (out_m21),
    .out_m22          (out_m22),
    .out_zero_error   (out_zero_error),
    .fail_count       (fail_count),
    .pending          (pending),
    .matrices_checked (matrices_checked),
    .zero_seen        (zero_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // present one quaternion after an optional gap; entered and left at a falling edge
  task automatic send_quat(input qcomp_t a, input qcomp_t b, input qcomp_t c, input qcomp_t d);
    int gap;
    gap = (nogap_left > 0) ? 0 : pick_gap();
    if (nogap_left > 0) nogap_left--;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_q_scalar <= a;
    in_q_x <= b;
    in_q_y <= c;
    in_q_z <= d;
    do @(posedge clk); while (!in_ready);
    quats_sent++;
    @(negedge clk);
  endtask

  // stop sending until every outstanding matrix has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // random quaternion: mostly full range, some tiny, some extreme, some degenerate
  task automatic rand_quat(output qcomp_t a, output qcomp_t b, output qcomp_t c,
                           output qcomp_t d);
    int     kind;
    qcomp_t picks [5];
    kind = $urandom_range(0, 99);
    picks = '{QMin, QMax, 16'sd0, -16'sd1, 16'sd1};
    a = qcomp_t'($urandom());
    b = qcomp_t'($urandom());
    c = qcomp_t'($urandom());
    d = qcomp_t'($urandom());
    if (kind >= 60 && kind < 80) begin
      a = qcomp_t'($urandom_range(0, 15)) - 16'sd8;
      b = qcomp_t'($urandom_range(0, 15)) - 16'sd8;
      c = qcomp_t'($urandom_range(0, 15)) - 16'sd8;
      d = qcomp_t'($urandom_range(0, 15)) - 16'sd8;
    end else if (kind >= 80 && kind < 88) begin
      a = picks[$urandom_range(0, 4)];
      b = picks[$urandom_range(0, 4)];
      c = picks[$urandom_range(0, 4)];
      d = picks[$urandom_range(0, 4)];
    end else if (kind >= 88 && kind < 94) begin
      // single axis left, the rest zero
      case ($urandom_range(0, 3))
        0: begin b = '0; c = '0; d = '0; end
        1: begin a = '0; c = '0; d = '0; end
        2: begin a = '0; b = '0; d = '0; end
        default: begin a = '0; b = '0; c = '0; end
      endcase
    end else if (kind >= 94) begin
      a = '0;
      b = '0;
      c = '0;
      d = '0;
    end
  endtask

  // receiver flow control: bursts of ready, random stalls, occasional long open stretch
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      repeat (hold) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
      repeat (pick_gap()) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("quaternion_to_rotation_matrix_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    qcomp_t ra, rb, rc, rd;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero quaternion, pure axes at QMin (scalar also at QMax), full-scale mixes, tiny values
    send_quat(0, 0, 0, 0);
    send_quat(QMax, 0, 0, 0);
    send_quat(QMin, 0, 0, 0);
    send_quat(0, QMin, 0, 0);
    send_quat(0, 0, QMin, 0);
    send_quat(0, 0, 0, QMin);
    send_quat(QMin, QMin, QMin, QMin);
    send_quat(QMax, QMax, QMax, QMax);
    send_quat(QMax, QMin, QMax, QMin);
    send_quat(QMin, QMax, 0, 1);
    send_quat(1, 0, 0, 0);
    send_quat(0, 0, 0, -1);
    send_quat(1, 1, 1, 0);
    send_quat(1, 2, 3, 4);
    send_quat(-1, 2, -3, 4);
    send_quat(0, 1, 1, 0);
    send_quat(16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00);
    send_quat(0, 0, 0, 0);
    send_quat(16'sh1234, -16'sd7, 16'sh7000, 16'sh8001);
    hold_until_drained();

    // random part with occasional back-to-back bursts and one drain midway
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 49) == 0) nogap_left = $urandom_range(20, 60);
      if (i == NumRandom / 2) hold_until_drained();
      rand_quat(ra, rb, rc, rd);
      send_quat(ra, rb, rc, rd);
    end

    // drain, then keep the inputs idle to catch stray matrices
    hold_until_drained();
    repeat (30) @(negedge clk);

    $display("sent %0d quaternions, compared %0d matrices (%0d from all-zero input)",
             quats_sent, matrices_checked, zero_seen);
    $display("directed axes and extremes, random full-range, tiny and degenerate values");
    if (fail_count == 0) begin
      $display("quaternion_to_rotation_matrix_unit verification clean");
    end else begin
      $display("quaternion_to_rotation_matrix_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/qdcm_pkg.sv
sv/quaternion_to_rotation_matrix_unit.sv
tb/dcm_checker.sv
tb/tb_quaternion_to_rotation_matrix_unit.sv
